### rtl/core/olist_pkg.sv
// package: shared types and constants of the ordered list block
`timescale 1ns / 1ps
package olist_pkg;

	localparam int CMD_W = 2;
	localparam int POS_W = 6;
	localparam int VAL_W = 32;
	localparam int ST_W  = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT  = 2'd0,
		CMD_DELETE  = 2'd1,
		CMD_SEARCH  = 2'd2,
		CMD_DISPLAY = 2'd3
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 3'd0,
		ST_BADPOS   = 3'd1,
		ST_FULL     = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DISP
	} state_t;

	// what a cell loads at the next edge
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_LOAD,
		OP_LEFT,
		OP_RIGHT,
		OP_HEAD
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     cmp;
		logic     live;
	} cell_ctl_t;

endpackage

### rtl/core/olist_ifs.sv
// interfaces: command and response channels of the ordered list block
`timescale 1ns / 1ps
interface olist_cmd_if;
	import olist_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [CMD_W-1:0]        cmd;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, cmd, position, value, input ready);
	modport sink (input valid, cmd, position, value, output ready);
endinterface

interface olist_rsp_if;
	import olist_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [ST_W-1:0]         status;
	logic [POS_W-1:0]        found_position;
	logic signed [VAL_W-1:0] entry_value;
	logic [POS_W-1:0]        entry_count;
	logic                    last;

	modport source (output valid, status, found_position, entry_value, entry_count, last,
		input ready);
	modport sink (input valid, status, found_position, entry_value, entry_count, last,
		output ready);
endinterface

### rtl/core/olist_cell.sv
// list cell: one stored entry, neighbor shift mux and match compare
`timescale 1ns / 1ps
module olist_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  olist_pkg::cell_ctl_t         ctl,
	input  logic [olist_pkg::VAL_W-1:0]  left_val,
	input  logic [olist_pkg::VAL_W-1:0]  right_val,
	input  logic [olist_pkg::VAL_W-1:0]  head_val,
	input  logic [olist_pkg::VAL_W-1:0]  load_val,
	input  logic [olist_pkg::VAL_W-1:0]  cmp_val,
	output logic [olist_pkg::VAL_W-1:0]  entry,
	output logic                         match
);
	import olist_pkg::*;

	logic [VAL_W-1:0] entry_q;
	logic             match_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LOAD:  entry_q <= load_val;
			OP_LEFT:  entry_q <= left_val;
			OP_RIGHT: entry_q <= right_val;
			OP_HEAD:  entry_q <= head_val;
			default:  entry_q <= entry_q;
		endcase
	end

	// only cells inside the list may report a hit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.cmp) begin
			match_q <= ctl.live && (entry_q == cmp_val);
		end
	end

	assign entry = entry_q;
	assign match = match_q;

endmodule

### rtl/core/ordered_list_insert_delete_search.sv
// top level: packed ordered list held in a chain of shifting cells
//
//  channel  dir  fields                                               transaction
//  cmd_ch   in   cmd, position, value                                 one command
//  rsp_ch   out  status, found_position, entry_value, entry_count,    one result
//                last
//
// insert, delete and search: the accept edge registers every cell's compare,
// then, once the output is free, the priority prefix runs and the shift is done;
// display gives one entry per cycle, unless stalled, as the chain rotates
// reset clears the fill count and control only; entries are not cleared
// a stalled result waits in the output register; the next command is taken
// meanwhile and executes once the register is free
`timescale 1ns / 1ps
module ordered_list_insert_delete_search #(
	parameter int DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	olist_cmd_if.sink   cmd_ch,
	olist_rsp_if.source rsp_ch
);
	import olist_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;
	localparam int LV = $clog2(DEPTH);

	// control
	state_t           state_q, state_nx;
	logic [CW-1:0]    count_q, count_nx;
	logic [CW-1:0]    disp_q, disp_nx;

	// accepted command
	logic [CMD_W-1:0] cmd_s1;
	logic [POS_W-1:0] pos_s1;
	logic [VAL_W-1:0] val_s1;

	// output register
	logic             rsp_valid_q;
	logic [ST_W-1:0]  st_q;
	logic [POS_W-1:0] fpos_q;
	logic [VAL_W-1:0] eval_q;
	logic [POS_W-1:0] ecnt_q;
	logic             last_q;

	logic             load_out;
	status_t          nx_st;
	logic [XW-1:0]    nx_fpos;
	logic [VAL_W-1:0] nx_val;
	logic             nx_last;

	logic             accept;
	logic             slot_free;
	logic             do_ins, do_del, do_rot;

	// cell chain
	logic [VAL_W-1:0] entry   [DEPTH];
	logic [VAL_W-1:0] left_w  [DEPTH];
	logic [VAL_W-1:0] right_w [DEPTH];
	logic [DEPTH-1:0] match;
	cell_ctl_t        ctl     [DEPTH];

	// first-match prefix network
	logic [DEPTH-1:0] pre [LV+1];
	logic [DEPTH-1:0] incl;
	logic [DEPTH-1:0] first;
	logic [XW-1:0]    enc;
	logic             found_any;

	logic [XW-1:0]    cnt_x, pos_x, ins_idx;
	logic             ins_full, ins_bad;

	assign accept    = cmd_ch.valid && cmd_ch.ready;
	assign slot_free = !rsp_valid_q || rsp_ch.ready;
	assign cmd_ch.ready = (state_q == S_IDLE);

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_ch.cmd;
			pos_s1 <= cmd_ch.position;
			val_s1 <= cmd_ch.value;
		end
	end

	// cells, each hands its entry to both neighbors
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		if (g == 0) begin : g_left_edge
			assign left_w[g] = entry[g];
		end else begin : g_left
			assign left_w[g] = entry[g-1];
		end
		if (g == DEPTH - 1) begin : g_right_edge
			assign right_w[g] = entry[g];
		end else begin : g_right
			assign right_w[g] = entry[g+1];
		end

		olist_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl[g]),
			.left_val  (left_w[g]),
			.right_val (right_w[g]),
			.head_val  (entry[0]),
			.load_val  (val_s1),
			.cmp_val   (cmd_ch.value),
			.entry     (entry[g]),
			.match     (match[g])
		);
	end

	// inclusive prefix or of the registered hits, log depth
	assign pre[0] = match;
	for (genvar l = 0; l < LV; l++) begin : g_lvl
		for (genvar i = 0; i < DEPTH; i++) begin : g_bit
			if (i >= (1 << l)) begin : g_or
				assign pre[l+1][i] = pre[l][i] | pre[l][i-(1<<l)];
			end else begin : g_pass
				assign pre[l+1][i] = pre[l][i];
			end
		end
	end
	assign incl      = pre[LV];
	assign first     = match & ~{incl[DEPTH-2:0], 1'b0};
	assign found_any = incl[DEPTH-1];

	always_comb begin
		enc = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (first[i]) begin
				enc = enc | XW'(i + 1);
			end
		end
	end

	assign cnt_x    = XW'(count_q);
	assign pos_x    = XW'(pos_s1);
	assign ins_idx  = pos_x - XW'(1);
	assign ins_full = (count_q >= CW'(DEPTH));
	assign ins_bad  = (pos_x == '0) || (pos_x > cnt_x + XW'(1));

	// sequencer
	always_comb begin
		state_nx = state_q;
		count_nx = count_q;
		disp_nx  = disp_q;
		load_out = 1'b0;
		nx_st    = ST_OK;
		nx_fpos  = '0;
		nx_val   = val_s1;
		nx_last  = 1'b1;
		do_ins   = 1'b0;
		do_del   = 1'b0;
		do_rot   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_nx = S_EXEC;
				end
			end
			S_EXEC: begin
				if (slot_free) begin
					state_nx = S_IDLE;
					unique case (cmd_s1)
						CMD_INSERT: begin
							load_out = 1'b1;
							if (ins_full) begin
								nx_st = ST_FULL;
							end else if (ins_bad) begin
								nx_st = ST_BADPOS;
							end else begin
								do_ins   = 1'b1;
								count_nx = count_q + CW'(1);
							end
						end
						CMD_DELETE: begin
							load_out = 1'b1;
							if (!found_any) begin
								nx_st = ST_NOTFOUND;
							end else begin
								do_del   = 1'b1;
								count_nx = count_q - CW'(1);
							end
						end
						CMD_SEARCH: begin
							load_out = 1'b1;
							if (!found_any) begin
								nx_st = ST_NOTFOUND;
							end else begin
								nx_fpos = enc;
							end
						end
						CMD_DISPLAY: begin
							if (count_q == '0) begin
								load_out = 1'b1;
								nx_st    = ST_EMPTY;
								nx_val   = '0;
							end else begin
								state_nx = S_DISP;
								disp_nx  = '0;
							end
						end
					endcase
				end
			end
			S_DISP: begin
				// head of the chain goes out, the list rotates by one
				if (slot_free) begin
					load_out = 1'b1;
					nx_val   = entry[0];
					nx_fpos  = XW'(disp_q) + XW'(1);
					nx_last  = ((disp_q + CW'(1)) == count_q);
					do_rot   = 1'b1;
					disp_nx  = disp_q + CW'(1);
					if (nx_last) begin
						state_nx = S_IDLE;
					end
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// per-cell shift selects
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ctl[i].cmp  = accept;
			ctl[i].live = (XW'(i) < cnt_x);
			ctl[i].op   = OP_HOLD;
			if (do_ins) begin
				if (XW'(i) == ins_idx) begin
					ctl[i].op = OP_LOAD;
				end else if (XW'(i) > ins_idx) begin
					ctl[i].op = OP_LEFT;
				end
			end else if (do_del) begin
				if (incl[i] && (i < DEPTH - 1)) begin
					ctl[i].op = OP_RIGHT;
				end
			end else if (do_rot) begin
				if (XW'(i) == cnt_x - XW'(1)) begin
					ctl[i].op = OP_HEAD;
				end else if (XW'(i) < cnt_x - XW'(1)) begin
					ctl[i].op = OP_RIGHT;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			disp_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			count_q <= count_nx;
			disp_q  <= disp_nx;
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ch.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			st_q   <= nx_st;
			fpos_q <= POS_W'(nx_fpos);
			eval_q <= nx_val;
			ecnt_q <= POS_W'(count_nx);
			last_q <= nx_last;
		end
	end

	assign rsp_ch.valid          = rsp_valid_q;
	assign rsp_ch.status         = st_q;
	assign rsp_ch.found_position = fpos_q;
	assign rsp_ch.entry_value    = eval_q;
	assign rsp_ch.entry_count    = ecnt_q;
	assign rsp_ch.last           = last_q;

endmodule

### rtl/core/olist_chk.sv
// checker: port-level properties of the ordered list block, bound to the top
`timescale 1ns / 1ps
module olist_chk #(
	parameter int DEPTH = 32
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cmd_valid,
	input logic                        cmd_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [olist_pkg::ST_W-1:0]  status,
	input logic [olist_pkg::POS_W-1:0] found_position,
	input logic [olist_pkg::POS_W-1:0] entry_count,
	input logic                        last
);
	import olist_pkg::*;

	// a response held back stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// one command at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command taken while one is executing");

	// errors are single results with no position
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != ST_OK) |-> last && (found_position == '0))
		else $error("error result not single or has a position");

	// inner display results are ok entries with a position
	a_disp_inner: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !last |-> (status == ST_OK) && (found_position != '0))
		else $error("bad inner display result");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ({1'b0, entry_count} <= (POS_W + 1)'(DEPTH)))
		else $error("entry count above depth");

endmodule

bind ordered_list_insert_delete_search olist_chk #(.DEPTH(DEPTH)) u_olist_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd_ch.valid),
	.cmd_ready      (cmd_ch.ready),
	.rsp_valid      (rsp_ch.valid),
	.rsp_ready      (rsp_ch.ready),
	.status         (rsp_ch.status),
	.found_position (rsp_ch.found_position),
	.entry_count    (rsp_ch.entry_count),
	.last           (rsp_ch.last)
);

### sim/ordered_list_insert_delete_search_tb.sv
// testbench: ordered list block driven by commands and checked against a scoreboard list
`timescale 1ns / 1ps
module ordered_list_insert_delete_search_tb;
	import olist_pkg::*;

	localparam int LIST_DEPTH   = 32;
	localparam int HALF_PERIOD  = 5;
	localparam int IDLE_LIMIT   = 2000;
	localparam int MIXED_ITEMS  = 100;

	// one response transaction as the block should produce it
	typedef struct {
		logic [ST_W-1:0]         status;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] value;
		logic [POS_W-1:0]        fill;
		logic                    last_flag;
	} list_result_t;

	// scoreboard: keeps its own copy of the list and the responses still owed
	class list_scoreboard;
		logic signed [VAL_W-1:0] cells[LIST_DEPTH];
		int                      fill;
		int                      errors;
		list_result_t            awaited[$];

		function new();
			fill = 0;
			errors = 0;
		endfunction

		function void queue_result(status_t st, int pos, logic signed [VAL_W-1:0] v,
			logic lst);
			list_result_t r;
			r.status = st;
			r.position = pos[POS_W-1:0];
			r.value = v;
			r.fill = fill[POS_W-1:0];
			r.last_flag = lst;
			awaited.push_back(r);
		endfunction

		// index of the first cell equal to v, fill when there is none
		function int locate(logic signed [VAL_W-1:0] v);
			int k;
			for (k = 0; k < fill; k++) begin
				if (cells[k] == v) begin
					return k;
				end
			end
			return fill;
		endfunction

		function void note_command(cmd_t c, logic [POS_W-1:0] p, logic signed [VAL_W-1:0] v);
			int slot;
			int k;
			slot = int'(p);
			case (c)
				CMD_INSERT: begin
					// a full list wins over a bad position
					if (fill >= LIST_DEPTH) begin
						queue_result(ST_FULL, 0, v, 1'b1);
					end else if (slot < 1 || slot > fill + 1) begin
						queue_result(ST_BADPOS, 0, v, 1'b1);
					end else begin
						for (k = fill; k > slot - 1; k--) begin
							cells[k] = cells[k - 1];
						end
						cells[slot - 1] = v;
						fill++;
						queue_result(ST_OK, 0, v, 1'b1);
					end
				end
				CMD_DELETE: begin
					k = locate(v);
					if (k >= fill) begin
						queue_result(ST_NOTFOUND, 0, v, 1'b1);
					end else begin
						while (k + 1 < fill) begin
							cells[k] = cells[k + 1];
							k++;
						end
						fill--;
						queue_result(ST_OK, 0, v, 1'b1);
					end
				end
				CMD_SEARCH: begin
					k = locate(v);
					if (k >= fill) begin
						queue_result(ST_NOTFOUND, 0, v, 1'b1);
					end else begin
						queue_result(ST_OK, k + 1, v, 1'b1);
					end
				end
				default: begin
					if (fill == 0) begin
						queue_result(ST_EMPTY, 0, '0, 1'b1);
					end else begin
						for (k = 0; k < fill; k++) begin
							queue_result(ST_OK, k + 1, cells[k], k + 1 == fill);
						end
					end
				end
			endcase
		endfunction

		task report(string what);
			$display("[%0t] mismatch: %s", $realtime, what);
			errors++;
		endtask

		task check_result(logic [ST_W-1:0] st, logic [POS_W-1:0] fp,
			logic signed [VAL_W-1:0] ev, logic [POS_W-1:0] ec, logic lst);
			list_result_t w;
			if (awaited.size() == 0) begin
				report($sformatf("response with nothing owed: status %0d value %0d", st, ev));
				return;
			end
			w = awaited.pop_front();
			if (st !== w.status) begin
				report($sformatf("status %0d, wanted %0d", st, w.status));
			end
			if (fp !== w.position) begin
				report($sformatf("found_position %0d, wanted %0d", fp, w.position));
			end
			if (ev !== w.value) begin
				report($sformatf("entry_value %0d, wanted %0d", ev, w.value));
			end
			if (ec !== w.fill) begin
				report($sformatf("entry_count %0d, wanted %0d", ec, w.fill));
			end
			if (lst !== w.last_flag) begin
				report($sformatf("last %0b, wanted %0b", lst, w.last_flag));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #HALF_PERIOD clk = ~clk;

	olist_cmd_if cmd_ch();
	olist_rsp_if rsp_ch();

	ordered_list_insert_delete_search #(
		.DEPTH(LIST_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_ch(cmd_ch),
		.rsp_ch(rsp_ch)
	);

	list_scoreboard sb = new();
	int sent = 0;

	// values often from a small pool so that duplicates and hits on delete and search are common
	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2: return $signed($urandom_range(0, 6)) - 3;
			3:       return 32'sh8000_0000;
			4:       return 32'sh7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// one command transaction; the sender idles for a drawn number of cycles first,
	// except in every fourth stretch of ten items where it runs back to back
	task automatic send_command(cmd_t c, logic [POS_W-1:0] p, logic signed [VAL_W-1:0] v);
		int gap;
		gap = ((sent % 40) < 10) ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			@(negedge clk) cmd_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		cmd_ch.valid <= 1'b1;
		cmd_ch.cmd <= c;
		cmd_ch.position <= p;
		cmd_ch.value <= v;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		sb.note_command(c, p, v);
		sent++;
	endtask

	// hold off new commands until every owed response has been taken
	task automatic drain();
		@(negedge clk) cmd_ch.valid <= 1'b0;
		while (sb.awaited.size() != 0) @(negedge clk);
	endtask

	// command side: directed cases, a fill to full, then a mixed random run
	initial begin
		int r;
		int n;
		bit grow;
		cmd_t c;
		logic [POS_W-1:0] p;
		logic signed [VAL_W-1:0] v;

		cmd_ch.valid = 1'b0;
		cmd_ch.cmd = CMD_INSERT;
		cmd_ch.position = '0;
		cmd_ch.value = '0;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// empty list: display, search and delete all report
		send_command(CMD_DISPLAY, 0, 0);
		send_command(CMD_SEARCH, 0, 5);
		send_command(CMD_DELETE, 0, 5);
		// bad positions on an empty list
		send_command(CMD_INSERT, 0, 7);
		send_command(CMD_INSERT, 2, 7);
		// build 7, 7, min, max with front, middle and end inserts
		send_command(CMD_INSERT, 1, 32'sh8000_0000);
		send_command(CMD_INSERT, 2, 32'sh7fff_ffff);
		send_command(CMD_INSERT, 1, 7);
		send_command(CMD_INSERT, 2, 7);
		// position beyond count+1, and the top of the field
		send_command(CMD_INSERT, 6, -1);
		send_command(CMD_INSERT, 63, -1);
		// duplicates: search must find the first one
		send_command(CMD_SEARCH, 41, 7);
		send_command(CMD_SEARCH, 0, 32'sh7fff_ffff);
		send_command(CMD_SEARCH, 0, 0);
		send_command(CMD_DISPLAY, 0, 0);
		send_command(CMD_DELETE, 0, 7);
		send_command(CMD_DELETE, 0, 32'sh7fff_ffff);
		send_command(CMD_DELETE, 0, 12345);
		send_command(CMD_SEARCH, 0, 32'sh8000_0000);
		send_command(CMD_DISPLAY, 0, 0);
		send_command(CMD_DELETE, 0, 7);
		send_command(CMD_DELETE, 0, 32'sh8000_0000);
		send_command(CMD_DISPLAY, 0, 0);
		drain();

		// fill to capacity at random positions, then hit the full list
		while (sb.fill < LIST_DEPTH) begin
			send_command(CMD_INSERT, POS_W'($urandom_range(1, sb.fill + 1)), pick_value());
		end
		send_command(CMD_INSERT, 1, pick_value());
		send_command(CMD_INSERT, 0, pick_value());
		send_command(CMD_SEARCH, 0, sb.cells[LIST_DEPTH - 1]);
		send_command(CMD_DISPLAY, 0, 0);

		// mixed run: the list swings between growing and shrinking so that both
		// the full and the empty corners are visited with random contents
		grow = 1'b0;
		for (n = 0; n < MIXED_ITEMS; n++) begin
			if (n == MIXED_ITEMS / 2) begin
				drain();
			end
			if (sb.fill == LIST_DEPTH && $urandom_range(0, 2) == 0) begin
				grow = 1'b0;
			end
			if (sb.fill == 0 && $urandom_range(0, 1) == 0) begin
				grow = 1'b1;
			end
			r = $urandom_range(0, 99);
			p = POS_W'($urandom_range(0, 63));
			v = pick_value();
			if (r < (grow ? 80 : 20)) begin
				c = CMD_INSERT;
				if ($urandom_range(0, 9) != 0) begin
					p = POS_W'($urandom_range(1, sb.fill + 1));
				end else if ($urandom_range(0, 1) == 0) begin
					p = 0;
				end else begin
					p = POS_W'($urandom_range(sb.fill + 2, 63));
				end
			end else begin
				if (r < (grow ? 88 : 75)) begin
					c = CMD_DELETE;
				end else if (r < 94) begin
					c = CMD_SEARCH;
				end else begin
					c = CMD_DISPLAY;
				end
				// mostly aim at something actually stored
				if (sb.fill > 0 && $urandom_range(0, 3) != 0) begin
					v = sb.cells[$urandom_range(0, sb.fill - 1)];
				end
			end
			send_command(c, p, v);
		end

		drain();
		// give any unexpected extra response time to show up before the verdict
		repeat (LIST_DEPTH + 8) @(posedge clk);
		if (sb.errors == 0 && sb.awaited.size() == 0) begin
			$display("PASS ordered_list_insert_delete_search");
		end else begin
			$display("FAIL ordered_list_insert_delete_search");
		end
		$finish;
	end

	// response side: ready drops for a drawn stall before each transaction, with
	// stretches of always-ready in between
	initial begin
		int stall;
		int taken;
		rsp_ch.ready = 1'b0;
		taken = 0;
		forever begin
			stall = ((taken / 30) % 3 == 0) ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				@(negedge clk) rsp_ch.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk) rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (rsp_ch.valid !== 1'b1);
			sb.check_result(rsp_ch.status, rsp_ch.found_position, rsp_ch.entry_value,
				rsp_ch.entry_count, rsp_ch.last);
			taken++;
		end
	end

	// watchdog: too many cycles without any transaction on either channel
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("FAIL ordered_list_insert_delete_search");
		$finish;
	end

endmodule

### files.f
rtl/core/olist_pkg.sv
rtl/core/olist_ifs.sv
rtl/core/olist_cell.sv
rtl/core/ordered_list_insert_delete_search.sv
rtl/core/olist_chk.sv
sim/ordered_list_insert_delete_search_tb.sv
